// ----- rtl/first_seen_value_ranker_macros.svh -----
// Assertion macros used by the checker of the first-seen value ranker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FIRST_SEEN_VALUE_RANKER_MACROS_SVH
`define FIRST_SEEN_VALUE_RANKER_MACROS_SVH

// Same-cycle implication, idle during reset
`define FSVR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsvr assertion failed");

// Next-cycle implication, idle during reset
`define FSVR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsvr assertion failed");

`endif

// ----- rtl/fsvr_pkg.sv -----
// Package for the first-seen value ranker: sizes, payload structs and the
// command/status structs between controller and datapath. No dependencies.
package fsvr_pkg;

	localparam int CAPACITY    = 256;
	localparam int STORE_LIMIT = 256;
	localparam int USABLE_CAP  = (CAPACITY < STORE_LIMIT) ? CAPACITY : STORE_LIMIT;
	localparam int ADDR_W      = (USABLE_CAP > 1) ? $clog2(USABLE_CAP) : 1;
	localparam int VALUE_W     = 32;
	localparam int RANK_W      = 8;
	localparam int COUNT_W     = 9;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [RANK_W-1:0]         rank_t;
	typedef logic [COUNT_W-1:0]        count_t;

	localparam count_t CAP_COUNT = COUNT_W'(USABLE_CAP);

	typedef struct packed {
		value_t value;
		logic   start_of_set;
	} in_item_t;

	typedef struct packed {
		rank_t  rank_id;
		logic   is_new;
		logic   overflow;
		count_t distinct_count;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // input transfer: latch value, apply start flag
		logic scan;    // step the table scan
		logic commit;  // write result, insert if unseen and room is left
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;       // compare stage matched
		logic scan_end;  // every stored entry compared, no match
		logic out_free;  // output register can take a result
	} dp_status_t;

endpackage

// ----- rtl/fsvr_ctrl.sv -----
// Controller of the first-seen value ranker: idle / scan / result sequencing.
// Depends on fsvr_pkg.
module fsvr_ctrl import fsvr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	state_t state_q;

	// Decode commands from the current state
	always_comb begin
		item_ready = (state_q == ST_IDLE);
		cmd.load   = item_valid && (state_q == ST_IDLE);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_RESULT) && status.out_free;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.hit || status.scan_end) state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/fsvr_datapath.sv -----
// Datapath of the first-seen value ranker: value table, scan pipeline,
// entry count and output register. Depends on fsvr_pkg.
module fsvr_datapath import fsvr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result
);

	value_t    seen_q [USABLE_CAP];
	value_t    value_q;
	count_t    count_q;
	count_t    addr_q;
	logic      rd_vld_s1;
	value_t    rd_data_s1;
	addr_t     rd_idx_s1;
	logic      found_q;
	addr_t     found_idx_q;
	out_item_t result_q;
	logic      result_valid_q;

	logic      launch;
	logic      hit;
	logic      insert;
	out_item_t result_d;

	// Scan compare and status
	always_comb begin
		launch          = cmd.scan && (addr_q < count_q);
		hit             = rd_vld_s1 && (rd_data_s1 == value_q);
		status.hit      = hit;
		status.scan_end = (addr_q >= count_q) && !hit;
		status.out_free = !result_valid_q || result_ready;
	end

	// Build the result from the finished scan
	always_comb begin
		insert                  = !found_q && (count_q < CAP_COUNT);
		result_d.is_new         = insert;
		result_d.overflow       = !found_q && !insert;
		result_d.distinct_count = insert ? count_q + COUNT_W'(1) : count_q;
		if (found_q) begin
			result_d.rank_id = RANK_W'(found_idx_q);
		end else if (insert) begin
			result_d.rank_id = count_q[RANK_W-1:0];
		end else begin
			result_d.rank_id = '0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			addr_q         <= '0;
			rd_vld_s1      <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (item.start_of_set) count_q <= '0;
				addr_q    <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
			end else begin
				rd_vld_s1 <= launch;
				if (launch) addr_q <= addr_q + COUNT_W'(1);
				if (cmd.scan && hit) found_q <= 1'b1;
				if (cmd.commit && insert) count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) value_q <= item.value;
		if (launch) rd_idx_s1 <= addr_q[ADDR_W-1:0];
		if (cmd.scan && hit) found_idx_q <= rd_idx_s1;
		if (cmd.commit) result_q <= result_d;
	end

	// Value table: one read port for the scan, one write port for inserts
	always_ff @(posedge clk) begin
		if (launch) rd_data_s1 <= seen_q[addr_q[ADDR_W-1:0]];
		if (cmd.commit && insert) seen_q[count_q[ADDR_W-1:0]] <= value_q;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/first_seen_value_ranker.sv -----
// First-seen value ranker (dictionary encoding). Each value is looked up in a
// table of the distinct values seen so far by a linear scan of the table memory,
// one stored entry per cycle through a registered read port; the first match
// ends the scan. An unseen value is appended with the next rank while room is
// left, otherwise it is flagged as overflow with rank 0. An item with the
// start flag set empties the table first. One item is handled at a time. The
// next input transfer can be taken in the cycle after the result is registered,
// so the memory scan sets the rate. The result sits in an output register, so
// a new item is taken while the previous result waits.
// Depends on fsvr_pkg, fsvr_ctrl and fsvr_datapath.
module first_seen_value_ranker import fsvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	fsvr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	fsvr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/fsvr_checker.sv -----
// Port-level checker for the first-seen value ranker, bound to the top level.
// Depends on fsvr_pkg and first_seen_value_ranker_macros.svh.
`include "first_seen_value_ranker_macros.svh"

module fsvr_checker import fsvr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	// Hold a stalled result
	`FSVR_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
	// Overflow carries rank 0 and no new mark
	`FSVR_ASSERT_NOW(a_ovf_rank, result_valid && result.overflow, result.rank_id == '0 && !result.is_new)
	// A new value takes the last rank of the table
	`FSVR_ASSERT_NOW(a_new_rank, result_valid && result.is_new, result.distinct_count == COUNT_W'(result.rank_id) + COUNT_W'(1))
	// A known value ranks within the table
	`FSVR_ASSERT_NOW(a_hit_rank, result_valid && !result.is_new && !result.overflow, COUNT_W'(result.rank_id) < result.distinct_count)

endmodule

bind first_seen_value_ranker fsvr_checker u_fsvr_checker (.*);
